// ===== rtl/core/spid_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package spid_pkg;

    // Width of the held interval register; the result field keeps 20 bits.
    localparam int IntervalBits = 20;
    localparam int OutIntervalBits = 20;
    localparam int HeldBits = (IntervalBits < OutIntervalBits) ? IntervalBits
                                                                : OutIntervalBits;

    localparam int SampleBits = 32;
    localparam int TotalBits = 32;
    localparam int SpacingBits = 20;
    localparam int ThreshBits = 16;
    localparam int LevelShift = 16;
    localparam int CfgDataBits = 20;
    localparam int CfgAddrBits = 1;

    localparam logic [SpacingBits-1:0] MinSpacingReset = 20'd200;
    localparam logic [ThreshBits-1:0] LevelThresholdReset = 16'd0;

    // Configuration register indexes
    localparam logic [CfgAddrBits-1:0] RegMinSpacing = 1'b0;
    localparam logic [CfgAddrBits-1:0] RegLevelThreshold = 1'b1;

    typedef struct packed {
        logic                       peak_found;
        logic [OutIntervalBits-1:0] interval;
        logic [TotalBits-1:0]       accepted_total;
        logic [TotalBits-1:0]       missed_total;
    } spid_res_t;

endpackage

`default_nettype wire

// ===== rtl/core/spid_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

module spid_core
    import spid_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CfgAddrBits-1:0] cfg_addr,
    input  wire logic [CfgDataBits-1:0] cfg_wr_data,
    input  wire logic                   in_valid,
    input  wire logic [SampleBits-1:0]  sample,
    output spid_res_t                   res
);

    logic [SpacingBits-1:0] min_spacing_reg;
    logic [ThreshBits-1:0]  thresh_reg;
    logic                   primed_reg, primed_next;
    logic                   falling_reg, falling_next;
    logic                   first_seen_reg, first_seen_next;
    logic [SampleBits-1:0]  prev_reg;
    logic [TotalBits-1:0]   cnt_reg, cnt_next;
    logic [HeldBits-1:0]    held_reg, held_next;
    logic [TotalBits-1:0]   acc_reg, acc_next;
    logic [TotalBits-1:0]   miss_reg, miss_next;

    logic [TotalBits-1:0]   cnt_inc;
    logic                   spaced, level_ok, turn_down, found;

    assign cnt_inc   = cnt_reg + 1'b1;
    assign spaced    = cnt_inc >= TotalBits'(min_spacing_reg);
    assign level_ok  = (thresh_reg == '0) ||
                       (sample[SampleBits-1:LevelShift] > thresh_reg);
    assign turn_down = primed_reg && !falling_reg && (sample < prev_reg);

    always_comb begin
        primed_next     = 1'b1;
        falling_next    = falling_reg;
        first_seen_next = first_seen_reg;
        cnt_next        = cnt_reg;
        held_next       = held_reg;
        acc_next        = acc_reg;
        miss_next       = miss_reg;
        found           = 1'b0;
        if (primed_reg) begin
            cnt_next = cnt_inc;
            if (turn_down) begin
                falling_next = 1'b1;
                cnt_next     = '0;
                if (!first_seen_reg) begin
                    first_seen_next = 1'b1;
                end else if (spaced && level_ok) begin
                    held_next = cnt_inc[HeldBits-1:0];
                    acc_next  = acc_reg + 1'b1;
                    found     = 1'b1;
                end else begin
                    miss_next = miss_reg + 1'b1;
                end
            end else if (falling_reg && (sample > prev_reg)) begin
                falling_next = 1'b0;
            end
        end
    end

    assign res.peak_found     = found;
    assign res.interval       = OutIntervalBits'(held_next);
    assign res.accepted_total = acc_next;
    assign res.missed_total   = miss_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_spacing_reg <= MinSpacingReset;
            thresh_reg      <= LevelThresholdReset;
            primed_reg      <= 1'b0;
            falling_reg     <= 1'b0;
            first_seen_reg  <= 1'b0;
            prev_reg        <= '0;
            cnt_reg         <= '0;
            held_reg        <= '0;
            acc_reg         <= '0;
            miss_reg        <= '0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    RegMinSpacing: begin
                        min_spacing_reg <= cfg_wr_data[SpacingBits-1:0];
                    end
                    RegLevelThreshold: begin
                        thresh_reg <= cfg_wr_data[ThreshBits-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (in_valid) begin
                primed_reg     <= primed_next;
                falling_reg    <= falling_next;
                first_seen_reg <= first_seen_next;
                prev_reg       <= sample;
                cnt_reg        <= cnt_next;
                held_reg       <= held_next;
                acc_reg        <= acc_next;
                miss_reg       <= miss_next;
            end
        end
    end

`ifndef SYNTHESIS
    a_peak_bumps_accepted: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && found) |=> (acc_reg == $past(acc_reg) + 1'b1))
        else $error("accepted peak did not advance the accepted total");

    a_totals_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid |=> !((acc_reg != $past(acc_reg)) && (miss_reg != $past(miss_reg))))
        else $error("one sample advanced both totals");

    a_idle_holds_counter: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid |=> ($stable(cnt_reg) && $stable(falling_reg)))
        else $error("slope state moved without a sample");

    a_turn_clears_counter: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && turn_down) |=> (cnt_reg == '0 && falling_reg))
        else $error("peak did not restart the counter");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/spid_out.sv =====
`timescale 1ns / 1ps
`default_nettype none

module spid_out
    import spid_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      push,
    input  wire spid_res_t push_data,
    output logic           can_push,
    output logic           out_valid,
    input  wire logic      out_ready,
    output spid_res_t      out_data
);

    logic      main_valid_reg;
    logic      skid_valid_reg;
    spid_res_t main_reg;
    spid_res_t skid_reg;
    logic      pop;

    assign pop       = main_valid_reg && out_ready;
    assign can_push  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!main_valid_reg || pop) begin
            // drain the skid word first; no push can arrive while it is full
            if (skid_valid_reg) begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                main_valid_reg <= push;
            end
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!main_valid_reg || pop) begin
            main_reg <= skid_valid_reg ? skid_reg : push_data;
        end else if (push) begin
            skid_reg <= push_data;
        end
    end

`ifndef SYNTHESIS
    a_skid_implies_main: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid word held while main stage empty");

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> !push)
        else $error("word pushed into a full buffer");

    a_skid_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && pop) |=> (main_valid_reg && !skid_valid_reg))
        else $error("skid word lost on drain");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/slope_peak_interval_detector.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Width  Contents (lowest bit first)
// s_*       in   32     tdata: sample[31:0]
// m_*       out  88     tdata: interval[19:0], accepted_total[51:20],
//                              missed_total[83:52], zero fill[87:84]
//                       tuser: peak_found
// cfg_*     in   1/20   index 0 min_spacing, index 1 level_threshold
//
// One word is taken every cycle while s_tready is high; the slope, counter
// and total update is a single combinational step from the state registers,
// so the output buffer registers its result on the edge that accepts the word.
// aresetn (synchronous) clears the core state and the buffer valid flags and restores both registers.
// A two-word output buffer keeps s_tready high while one result waits;
// s_tready drops only when both buffer words are held.

module slope_peak_interval_detector
    import spid_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // configuration write port
    input  wire logic                   cfg_wr_en,
    input  wire logic [CfgAddrBits-1:0] cfg_addr,
    input  wire logic [CfgDataBits-1:0] cfg_wr_data,
    // input stream
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [31:0]            s_tdata,   // sample[31:0]
    // result stream
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [87:0]                 m_tdata,   // interval, accepted_total,
                                                   // missed_total, zero fill
    output logic                        m_tuser    // peak_found
);

    logic      in_valid;
    spid_res_t core_res;
    spid_res_t out_res;

    // accept a word whenever the output buffer has room
    assign in_valid = s_tvalid && s_tready;

    spid_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .sample      (s_tdata),
        .res         (core_res)
    );

    spid_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (in_valid),
        .push_data (core_res),
        .can_push  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    // pack the result word; peak_found rides on tuser
    assign m_tdata = {4'b0000, out_res.missed_total, out_res.accepted_total,
                      out_res.interval};
    assign m_tuser = out_res.peak_found;

endmodule

`default_nettype wire
